// File: hdl/lcdseq_pkg.sv
`timescale 1ns / 1ps

package lcdseq_pkg;

  // command kinds
  localparam logic [2:0] KIND_INIT   = 3'd0;
  localparam logic [2:0] KIND_CLEAR  = 3'd1;
  localparam logic [2:0] KIND_CHAR   = 3'd2;
  localparam logic [2:0] KIND_ADDR   = 3'd3;
  localparam logic [2:0] KIND_LINE   = 3'd4;
  localparam logic [2:0] KIND_CURSOR = 3'd5;

  localparam logic [1:0] LINE_ONE = 2'd1;
  localparam logic [1:0] LINE_TWO = 2'd2;

  localparam logic [7:0] CMD_CLEAR     = 8'h01;
  localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
  localparam logic [7:0] LINE_TWO_BASE = 8'h40;
  localparam logic [3:0] CMD_DISPLAY   = 4'hC;

  localparam int unsigned BEFORE_W = 17;
  localparam int unsigned AFTER_W  = 13;

  localparam logic [BEFORE_W-1:0] CMD_BEFORE_US  = 17'd10000;
  localparam logic [BEFORE_W-1:0] CHAR_BEFORE_US = 17'd500;
  localparam logic [AFTER_W-1:0]  CMD_AFTER_US   = 13'd5000;
  localparam logic [AFTER_W-1:0]  CHAR_AFTER_US  = 13'd500;
  localparam logic [AFTER_W-1:0]  CURSOR_AFTER_US = 13'd100;

  localparam int unsigned INIT_LEN = 12;
  localparam int unsigned STEP_W   = 4;

  localparam int unsigned FIFO_DEPTH = 2;

  // one classified command: either the init run or a single byte
  typedef struct packed {
    logic                is_init;
    logic                rs;
    logic [7:0]          data;
    logic [BEFORE_W-1:0] before_us;
    logic [AFTER_W-1:0]  after_us;
  } lcdseq_desc_t;

  typedef struct packed {
    logic [3:0]          nibble;
    logic [BEFORE_W-1:0] before_us;
    logic [AFTER_W-1:0]  after_us;
  } init_write_t;

  // power-up run: 3,3,3,2 then bytes 0x28, 0x08, 0x01, 0x06
  function automatic init_write_t init_write(input logic [STEP_W-1:0] step);
    init_write_t w;
    w = '0;
    unique case (step)
      4'd0:  w = '{4'h3, 17'd100000, 13'd5000};
      4'd1:  w = '{4'h3, 17'd0, 13'd100};
      4'd2:  w = '{4'h3, 17'd0, 13'd100};
      4'd3:  w = '{4'h2, 17'd0, 13'd100};
      4'd4:  w = '{4'h2, 17'd0, 13'd0};
      4'd5:  w = '{4'h8, 17'd0, 13'd60};
      4'd6:  w = '{4'h0, 17'd0, 13'd0};
      4'd7:  w = '{4'h8, 17'd0, 13'd60};
      4'd8:  w = '{4'h0, 17'd0, 13'd0};
      4'd9:  w = '{4'h1, 17'd0, 13'd5000};
      4'd10: w = '{4'h0, 17'd0, 13'd0};
      4'd11: w = '{4'h6, 17'd0, 13'd100};
      default: w = '0;
    endcase
    return w;
  endfunction

endpackage

// File: hdl/lcdseq_front.sv
`timescale 1ns / 1ps

module lcdseq_front import lcdseq_pkg::*; (
  input  logic         push,
  input  logic         q_full_i,
  input  logic [2:0]   kind_i,
  input  logic [7:0]   char_code_i,
  input  logic [6:0]   ddram_address_i,
  input  logic [1:0]   line_number_i,
  input  logic         show_cursor_i,
  input  logic         blink_cursor_i,
  output logic         full,
  output logic         q_wr_o,
  output lcdseq_desc_t q_wdata_o
);

  logic cmd_valid;

  always_comb begin
    cmd_valid = 1'b1;
    q_wdata_o = '0;
    q_wdata_o.before_us = CMD_BEFORE_US;
    q_wdata_o.after_us  = CMD_AFTER_US;
    unique case (kind_i)
      KIND_INIT: begin
        q_wdata_o.is_init = 1'b1;
      end
      KIND_CLEAR: begin
        q_wdata_o.data = CMD_CLEAR;
      end
      KIND_CHAR: begin
        q_wdata_o.rs        = 1'b1;
        q_wdata_o.data      = char_code_i;
        q_wdata_o.before_us = CHAR_BEFORE_US;
        q_wdata_o.after_us  = CHAR_AFTER_US;
      end
      KIND_ADDR: begin
        q_wdata_o.data = CMD_SET_DDRAM | {1'b0, ddram_address_i};
      end
      KIND_LINE: begin
        // lines other than one and two produce nothing
        cmd_valid      = (line_number_i == LINE_ONE) || (line_number_i == LINE_TWO);
        q_wdata_o.data = (line_number_i == LINE_TWO) ? (CMD_SET_DDRAM | LINE_TWO_BASE)
                                                     : CMD_SET_DDRAM;
      end
      KIND_CURSOR: begin
        q_wdata_o.data     = {4'h0, CMD_DISPLAY | {2'b00, show_cursor_i, blink_cursor_i}};
        q_wdata_o.after_us = CURSOR_AFTER_US;
      end
      default: begin
        cmd_valid = 1'b0;
      end
    endcase
  end

  assign full   = q_full_i;
  assign q_wr_o = push && !q_full_i && cmd_valid;

endmodule

// File: hdl/lcdseq_fifo.sv
`timescale 1ns / 1ps

module lcdseq_fifo import lcdseq_pkg::*; #(
  parameter int unsigned Depth = FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         wr_i,
  input  lcdseq_desc_t wdata_i,
  output logic         full_o,
  input  logic         rd_i,
  output lcdseq_desc_t rdata_o,
  output logic         empty_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  lcdseq_desc_t    mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            wr_en, rd_en;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = wr_i && !full_o;
  assign rd_en   = rd_i && !empty_o;
  assign rdata_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (wr_en) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (rd_en) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (wr_en && !rd_en) begin
      cnt_d = cnt_q + 1'b1;
    end else if (rd_en && !wr_en) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_ptr_q] <= wdata_i;
    end
  end

endmodule

// File: hdl/lcdseq_back.sv
`timescale 1ns / 1ps

module lcdseq_back import lcdseq_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_empty_i,
  input  lcdseq_desc_t        q_head_i,
  output logic                q_rd_o,
  output logic                empty,
  input  logic                pop,
  output logic                reg_select_o,
  output logic [3:0]          nibble_o,
  output logic [BEFORE_W-1:0] wait_before_us_o,
  output logic [AFTER_W-1:0]  wait_after_us_o,
  output logic                last_write_o
);

  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic                rs_q;
  logic [3:0]          nib_q;
  logic [BEFORE_W-1:0] before_q;
  logic [AFTER_W-1:0]  after_q;
  logic                last_q;

  logic                advance;
  logic                wr_last;
  logic [3:0]          wr_nib;
  logic [BEFORE_W-1:0] wr_before;
  logic [AFTER_W-1:0]  wr_after;
  init_write_t         iw;

  assign advance = !q_empty_i && (!out_valid_q || pop);
  assign iw      = init_write(step_q);

  always_comb begin
    if (q_head_i.is_init) begin
      wr_nib    = iw.nibble;
      wr_before = iw.before_us;
      wr_after  = iw.after_us;
      wr_last   = (step_q == STEP_W'(INIT_LEN - 1));
    end else if (step_q == '0) begin
      // high nibble first
      wr_nib    = q_head_i.data[7:4];
      wr_before = q_head_i.before_us;
      wr_after  = '0;
      wr_last   = 1'b0;
    end else begin
      wr_nib    = q_head_i.data[3:0];
      wr_before = '0;
      wr_after  = q_head_i.after_us;
      wr_last   = 1'b1;
    end
  end

  assign q_rd_o = advance && wr_last;

  always_comb begin
    step_d      = step_q;
    out_valid_d = out_valid_q;
    if (pop && out_valid_q) begin
      out_valid_d = 1'b0;
    end
    if (advance) begin
      out_valid_d = 1'b1;
      step_d      = wr_last ? '0 : step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      rs_q     <= q_head_i.rs;
      nib_q    <= wr_nib;
      before_q <= wr_before;
      after_q  <= wr_after;
      last_q   <= wr_last;
    end
  end

  assign empty            = !out_valid_q;
  assign reg_select_o     = rs_q;
  assign nibble_o         = nib_q;
  assign wait_before_us_o = before_q;
  assign wait_after_us_o  = after_q;
  assign last_write_o     = last_q;

  // step never runs past the init run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q < STEP_W'(INIT_LEN))
    else $error("step counter out of range");

  // a byte command takes two writes only
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!q_empty_i && !q_head_i.is_init) |-> (step_q <= STEP_W'(1)))
    else $error("byte command past its second nibble");

  // mid-command the head request must still be queued
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step_q != '0) |-> !q_empty_i)
    else $error("command dropped mid-sequence");

  // final write of a command restarts the step count
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (advance && wr_last) |=> (step_q == '0))
    else $error("step not cleared after last write");

endmodule

// File: hdl/char_lcd_nibble_command_sequencer.sv
`timescale 1ns / 1ps

// Expands display commands into 4-bit bus writes, one write per clock on the
// result side while pop takes each write. Init yields twelve writes, set-line
// with a line other than 1 or 2 and unknown kinds yield none, every other
// command yields two (high nibble first). The input side takes a request every
// cycle while the command queue between the decoder and the nibble stepper
// has room. The first write of a request passes through the command queue and
// then the stepper's output register before it shows on the result side.
// Sustained rate is set by the stepper emitting one nibble per cycle while pop
// takes them, so it depends on the command's kind; commands that yield no
// writes never enter the queue.
module char_lcd_nibble_command_sequencer import lcdseq_pkg::*; #(
  parameter int unsigned QueueDepth = FIFO_DEPTH
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push,
  output logic                full,
  input  logic [2:0]          kind_i,
  input  logic [7:0]          char_code_i,
  input  logic [6:0]          ddram_address_i,
  input  logic [1:0]          line_number_i,
  input  logic                show_cursor_i,
  input  logic                blink_cursor_i,
  output logic                empty,
  input  logic                pop,
  output logic                reg_select_o,
  output logic [3:0]          nibble_o,
  output logic [BEFORE_W-1:0] wait_before_us_o,
  output logic [AFTER_W-1:0]  wait_after_us_o,
  output logic                last_write_o
);

  logic         q_wr, q_full, q_rd, q_empty;
  lcdseq_desc_t q_wdata, q_head;

  lcdseq_front u_front (
    .push            (push),
    .q_full_i        (q_full),
    .kind_i          (kind_i),
    .char_code_i     (char_code_i),
    .ddram_address_i (ddram_address_i),
    .line_number_i   (line_number_i),
    .show_cursor_i   (show_cursor_i),
    .blink_cursor_i  (blink_cursor_i),
    .full            (full),
    .q_wr_o          (q_wr),
    .q_wdata_o       (q_wdata)
  );

  lcdseq_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .wr_i    (q_wr),
    .wdata_i (q_wdata),
    .full_o  (q_full),
    .rd_i    (q_rd),
    .rdata_o (q_head),
    .empty_o (q_empty)
  );

  lcdseq_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_empty_i        (q_empty),
    .q_head_i         (q_head),
    .q_rd_o           (q_rd),
    .empty            (empty),
    .pop              (pop),
    .reg_select_o     (reg_select_o),
    .nibble_o         (nibble_o),
    .wait_before_us_o (wait_before_us_o),
    .wait_after_us_o  (wait_after_us_o),
    .last_write_o     (last_write_o)
  );

endmodule
